// ----- sv/slc_pkg.sv -----
// ----------------------------------------------------------------------------
// slc_pkg
// Types, codes and the end-of-line decision for the screenplay line classifier.
// ----------------------------------------------------------------------------
package slc_pkg;

    // Input item: one text byte or an end-of-line marker
    typedef struct packed {
        logic       mode;
        logic [7:0] char_code;
    } slc_in_t;

    // Result item: class of the finished line
    typedef struct packed {
        logic [2:0] line_class;
        logic       strip_first;
    } slc_out_t;

    // Line classes
    typedef enum logic [2:0] {
        CLS_EMPTY      = 3'd0,
        CLS_ACTION     = 3'd1,
        CLS_SCENE      = 3'd2,
        CLS_CHARACTER  = 3'd3,
        CLS_PAREN      = 3'd4,
        CLS_DIALOGUE   = 3'd5,
        CLS_TRANSITION = 3'd6,
        CLS_CONTINUE   = 3'd7
    } line_class_t;

    // Item modes
    localparam logic MODE_BYTE = 1'b0;
    localparam logic MODE_EOL  = 1'b1;

    // Length saturates here; no rule looks beyond it
    localparam logic [3:0] LEN_CAP = 4'd8;
    localparam logic [3:0] LEN_ONE = 4'd1;
    localparam logic [3:0] LEN_TWO = 4'd2;
    localparam logic [3:0] LEN_THREE = 4'd3;

    // Characters and three-byte patterns
    localparam logic [7:0]  CHR_BANG   = 8'h21;
    localparam logic [7:0]  CHR_LPAREN = 8'h28;
    localparam logic [7:0]  CHR_RPAREN = 8'h29;
    localparam logic [7:0]  CHR_LOW_A  = 8'h61;
    localparam logic [7:0]  CHR_LOW_Z  = 8'h7a;
    localparam logic [23:0] PFX_INT    = 24'h494e54;
    localparam logic [23:0] PFX_EXT    = 24'h455854;
    localparam logic [23:0] PFX_EST    = 24'h455354;
    localparam logic [23:0] PFX_IE     = 24'h492f45;
    localparam logic [23:0] SFX_TO     = 24'h544f3a;

    // Facts gathered over one line
    typedef struct packed {
        logic [3:0]  line_length;
        logic [23:0] first_three;
        logic [23:0] last_three;
        logic        no_lowercase;
    } slc_facts_t;

    // Decide the class of a finished line
    function automatic slc_out_t slc_classify(input slc_facts_t f, input line_class_t prev);
        slc_out_t    res;
        line_class_t cls;
        logic [7:0]  first_byte;
        logic [7:0]  last_byte;
        logic        heading;
        // first byte sits lower until three bytes are in
        if (f.line_length >= LEN_THREE) begin
            first_byte = f.first_three[23:16];
        end else if (f.line_length == LEN_TWO) begin
            first_byte = f.first_three[15:8];
        end else begin
            first_byte = f.first_three[7:0];
        end
        last_byte = f.last_three[7:0];
        heading = (f.first_three == PFX_INT) || (f.first_three == PFX_EXT) ||
                  (f.first_three == PFX_EST) || (f.first_three == PFX_IE);
        res.strip_first = 1'b0;
        if (f.line_length == 4'd0) begin
            cls = CLS_EMPTY;
        end else if (first_byte == CHR_BANG) begin
            cls = CLS_ACTION;
            res.strip_first = 1'b1;
        end else if (f.line_length >= LEN_CAP && heading) begin
            cls = CLS_SCENE;
        end else if (prev == CLS_EMPTY && f.line_length >= LEN_THREE &&
                     f.last_three == SFX_TO && f.no_lowercase) begin
            cls = CLS_TRANSITION;
        end else if (prev == CLS_EMPTY && f.no_lowercase) begin
            cls = CLS_CHARACTER;
        end else if (prev == CLS_CHARACTER && f.line_length >= LEN_TWO &&
                     first_byte == CHR_LPAREN && last_byte == CHR_RPAREN) begin
            cls = CLS_PAREN;
        end else if (prev == CLS_CHARACTER || prev == CLS_PAREN) begin
            cls = CLS_DIALOGUE;
        end else if (prev == CLS_DIALOGUE || prev == CLS_ACTION) begin
            cls = CLS_CONTINUE;
        end else begin
            cls = CLS_ACTION;
        end
        res.line_class = cls;
        return res;
    endfunction

endpackage

// ----- sv/screenplay_line_classifier_unit.sv -----
// ----------------------------------------------------------------------------
// screenplay_line_classifier_unit
// Classifies screenplay text lines streamed one byte per item.
// ----------------------------------------------------------------------------
//  Channel | Ports                      | Item
//  --------+----------------------------+------------------------------------
//  input   | s_valid, s_ready, s_item   | text byte or end of line (slc_in_t)
//  result  | m_valid, m_ready, m_item   | line class, strip flag (slc_out_t)
//
//  One item per cycle. A byte updates the line fact registers at acceptance;
//  an end of line is classified from those registers and the result register
//  holds its class from the next cycle on. Reset clears facts, previous class
//  and the result valid flag. Input is stalled only while a result waits and
//  m_ready is low; a result taken in a cycle frees room for a new item then.
// ----------------------------------------------------------------------------
module screenplay_line_classifier_unit
    import slc_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  slc_in_t  s_item,
    output logic     m_valid,
    input  logic     m_ready,
    output slc_out_t m_item
);

    logic        accept;
    logic        byte_en;
    logic        eol_en;
    slc_facts_t  facts;
    slc_out_t    cls_res;
    line_class_t prev_class_reg;
    line_class_t prev_class_next;
    logic        m_valid_reg;
    logic        m_valid_next;
    slc_out_t    m_item_reg;

    // Accept whenever the result register is empty or draining
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign byte_en = accept && (s_item.mode == MODE_BYTE);
    assign eol_en  = accept && (s_item.mode == MODE_EOL);

    slc_line_facts u_facts (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .byte_en   (byte_en),
        .eol_en    (eol_en),
        .char_code (s_item.char_code),
        .facts     (facts)
    );

    // Classify the finished line; continuation keeps the previous class
    always_comb begin
        cls_res         = slc_classify(facts, prev_class_reg);
        prev_class_next = prev_class_reg;
        if (eol_en && (cls_res.line_class != CLS_CONTINUE)) begin
            prev_class_next = line_class_t'(cls_res.line_class);
        end
    end

    // Result valid: set on end of line, drop when taken
    always_comb begin
        m_valid_next = m_valid_reg;
        if (eol_en) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_class_reg <= CLS_EMPTY;
            m_valid_reg    <= 1'b0;
        end else begin
            prev_class_reg <= prev_class_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Hold the result payload until the next end of line
    always_ff @(posedge aclk) begin
        if (eol_en) begin
            m_item_reg <= cls_res;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

// ----- sv/slc_line_facts.sv -----
// ----------------------------------------------------------------------------
// slc_line_facts
// Per-line fact registers: saturating length, first and last three bytes,
// lowercase flag. Cleared at each end of line.
// ----------------------------------------------------------------------------
module slc_line_facts
    import slc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       byte_en,
    input  logic       eol_en,
    input  logic [7:0] char_code,
    output slc_facts_t facts
);

    slc_facts_t facts_reg;
    slc_facts_t facts_next;

    // Fold one byte into the facts, or clear at end of line
    always_comb begin
        facts_next = facts_reg;
        if (eol_en) begin
            facts_next.line_length  = 4'd0;
            facts_next.first_three  = 24'd0;
            facts_next.last_three   = 24'd0;
            facts_next.no_lowercase = 1'b1;
        end else if (byte_en) begin
            if (facts_reg.line_length < LEN_THREE) begin
                facts_next.first_three = {facts_reg.first_three[15:0], char_code};
            end
            facts_next.last_three = {facts_reg.last_three[15:0], char_code};
            if (char_code >= CHR_LOW_A && char_code <= CHR_LOW_Z) begin
                facts_next.no_lowercase = 1'b0;
            end
            if (facts_reg.line_length < LEN_CAP) begin
                facts_next.line_length = facts_reg.line_length + LEN_ONE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            facts_reg.line_length  <= 4'd0;
            facts_reg.first_three  <= 24'd0;
            facts_reg.last_three   <= 24'd0;
            facts_reg.no_lowercase <= 1'b1;
        end else begin
            facts_reg <= facts_next;
        end
    end

    assign facts = facts_reg;

endmodule

// ----- tb/sv/screenplay_line_classifier_unit_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// screenplay_line_classifier_unit_test
// Streams screenplay text at the classifier as byte and end-of-line items. A
// directed opening walks every line class at least once. Random scene, dialogue,
// action, heading and transition blocks follow, mixed with noise and
// malformed lines. Both channels idle at random. Each end of line is tracked
// here to predict its class, and results are checked in order.
// ----------------------------------------------------------------------------
module screenplay_line_classifier_unit_test;
    import slc_pkg::*;

    localparam int RANDOM_ITEMS = 1650;

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    slc_in_t  s_item  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    slc_out_t m_item;

    screenplay_line_classifier_unit DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    // Text items waiting to be sent and line classes waiting to come back
    slc_in_t  script_items[$];
    slc_out_t expected_classes[$];
    slc_out_t oldest_class;
    int       items_taken    = 0;
    int       total_items    = 0;
    int       mismatch_count = 0;
    logic     calm           = 1'b0;

    // Facts about the line being streamed, plus the last kept class
    logic [3:0]  seen_len   = '0;
    logic [23:0] head_bytes = '0;
    logic [23:0] tail_bytes = '0;
    logic [7:0]  lead_char  = '0;
    logic        caps_only  = 1'b1;
    line_class_t last_kept  = CLS_EMPTY;

    initial begin
        forever #4 aclk = ~aclk;
    end

    // Update line facts on a byte; on an end of line, predict its class
    task automatic track_screenplay_item(input slc_in_t it);
        slc_out_t    want;
        line_class_t cls;
        logic        heading;
        if (it.mode == MODE_BYTE) begin
            if (seen_len == 4'd0) begin
                lead_char = it.char_code;
            end
            if (seen_len < LEN_THREE) begin
                head_bytes = {head_bytes[15:0], it.char_code};
            end
            tail_bytes = {tail_bytes[15:0], it.char_code};
            if (it.char_code >= CHR_LOW_A && it.char_code <= CHR_LOW_Z) begin
                caps_only = 1'b0;
            end
            if (seen_len != LEN_CAP) begin
                seen_len = seen_len + LEN_ONE;
            end
        end else begin
            case (head_bytes)
                PFX_INT, PFX_EXT, PFX_EST, PFX_IE: heading = 1'b1;
                default:                           heading = 1'b0;
            endcase
            want.strip_first = 1'b0;
            if (seen_len == 4'd0) begin
                cls = CLS_EMPTY;
            end else if (lead_char == CHR_BANG) begin
                cls = CLS_ACTION;
                want.strip_first = 1'b1;
            end else if (seen_len == LEN_CAP && heading) begin
                cls = CLS_SCENE;
            end else if (last_kept == CLS_EMPTY && caps_only) begin
                // a shouted line after a blank is a transition if it ends in TO:
                if (seen_len >= LEN_THREE && tail_bytes == SFX_TO) begin
                    cls = CLS_TRANSITION;
                end else begin
                    cls = CLS_CHARACTER;
                end
            end else if (last_kept == CLS_CHARACTER && seen_len >= LEN_TWO &&
                         lead_char == CHR_LPAREN && tail_bytes[7:0] == CHR_RPAREN) begin
                cls = CLS_PAREN;
            end else if (last_kept == CLS_CHARACTER || last_kept == CLS_PAREN) begin
                cls = CLS_DIALOGUE;
            end else if (last_kept == CLS_DIALOGUE || last_kept == CLS_ACTION) begin
                cls = CLS_CONTINUE;
            end else begin
                cls = CLS_ACTION;
            end
            want.line_class = cls;
            expected_classes = {expected_classes, want};
            if (cls != CLS_CONTINUE) begin
                last_kept = cls;
            end
            seen_len   = '0;
            head_bytes = '0;
            tail_bytes = '0;
            caps_only  = 1'b1;
        end
    endtask

    // Byte makers: shouted text without lowercase, and ordinary prose
    function automatic logic [7:0] caps_byte();
        case ($urandom_range(9))
            0:       caps_byte = 8'h20;
            1:       caps_byte = 8'($urandom_range(48, 57));
            2:       caps_byte = 8'($urandom_range(128, 255));
            3:       caps_byte = 8'($urandom_range(34, 64));
            4:       caps_byte = 8'($urandom_range(91, 96));
            5:       caps_byte = 8'($urandom_range(123, 127));
            default: caps_byte = 8'($urandom_range(65, 90));
        endcase
    endfunction

    function automatic logic [7:0] prose_byte();
        case ($urandom_range(9))
            0:       prose_byte = 8'h20;
            1:       prose_byte = caps_byte();
            2:       prose_byte = 8'($urandom_range(33, 64));
            default: prose_byte = 8'($urandom_range(CHR_LOW_A, CHR_LOW_Z));
        endcase
    endfunction

    task automatic put_byte(input logic [7:0] c);
        slc_in_t it;
        it.mode      = MODE_BYTE;
        it.char_code = c;
        script_items = {script_items, it};
    endtask

    task automatic put_eol();
        slc_in_t it;
        it.mode      = MODE_EOL;
        it.char_code = 8'($urandom_range(255));
        script_items = {script_items, it};
    endtask

    task automatic put_text(input string s);
        for (int k = 0; k < s.len(); k++) begin
            put_byte(s[k]);
        end
    endtask

    task automatic put_caps_line(input int lo, input int hi);
        int n;
        n = $urandom_range(lo, hi);
        repeat (n) put_byte(caps_byte());
        put_eol();
    endtask

    task automatic put_prose_line();
        int n;
        n = ($urandom_range(7) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
        repeat (n) put_byte(prose_byte());
        put_eol();
    endtask

    task automatic put_paren_line();
        put_byte(CHR_LPAREN);
        repeat ($urandom_range(0, 6)) put_byte(prose_byte());
        if ($urandom_range(5) != 0) begin
            put_byte(CHR_RPAREN);
        end
        put_eol();
    endtask

    task automatic put_heading_line();
        int n;
        n = ($urandom_range(7) == 0) ? $urandom_range(3, 7) : $urandom_range(8, 16);
        case ($urandom_range(3))
            0:       put_text("INT");
            1:       put_text("EXT");
            2:       put_text("EST");
            default: put_text("I/E");
        endcase
        repeat (n - 3) put_byte(prose_byte());
        put_eol();
    endtask

    task automatic put_transition_line();
        if ($urandom_range(4) == 0) begin
            put_byte(prose_byte());
        end
        repeat ($urandom_range(0, 8)) put_byte(caps_byte());
        put_text("TO:");
        put_eol();
    endtask

    // Near misses of the patterns the block looks for
    task automatic put_broken_line();
        case ($urandom_range(4))
            0: begin
                put_text("Int");
                repeat ($urandom_range(5, 9)) put_byte(caps_byte());
            end
            1: begin
                put_text("EXT");
                repeat ($urandom_range(0, 4)) put_byte(caps_byte());
            end
            2: begin
                repeat ($urandom_range(0, 5)) put_byte(caps_byte());
                put_text("To:");
            end
            3: begin
                repeat ($urandom_range(0, 5)) put_byte(caps_byte());
                put_text("TO");
            end
            default: begin
                put_byte(CHR_RPAREN);
                put_byte(CHR_LPAREN);
            end
        endcase
        put_eol();
    endtask

    task automatic put_noise_line();
        repeat ($urandom_range(0, 20)) put_byte(8'($urandom_range(255)));
        put_eol();
    endtask

    // Feed the input channel; hold the item until it is accepted
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                track_screenplay_item(s_item);
                items_taken++;
            end
            calm <= (items_taken >= 700 && items_taken < 1000);
            if (!s_valid || s_ready) begin
                if (script_items.size() != 0 && (calm || $urandom_range(99) >= 18)) begin
                    s_item  <= script_items.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Check each line class against the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_classes.size() == 0) begin
                $display("%0t: unexpected result, actual class %0d strip %0b",
                         $time, m_item.line_class, m_item.strip_first);
                mismatch_count++;
            end else begin
                oldest_class = expected_classes.pop_front();
                if (m_item.line_class !== oldest_class.line_class) begin
                    $display("%0t: line_class expected %0d actual %0d",
                             $time, oldest_class.line_class, m_item.line_class);
                    mismatch_count++;
                end
                if (m_item.strip_first !== oldest_class.strip_first) begin
                    $display("%0t: strip_first expected %0b actual %0b",
                             $time, oldest_class.strip_first, m_item.strip_first);
                    mismatch_count++;
                end
            end
        end
        m_ready <= calm || $urandom_range(99) >= 18;
    end

    initial begin
        int guard;

        // Directed lines: each class at least once and the odd corners
        put_eol();
        put_byte(CHR_BANG);
        put_eol();
        put_text("a");                      // follows an action: continuation
        put_eol();
        put_eol();
        put_text("TO:");                    // shortest transition
        put_eol();
        put_eol();
        put_byte(8'hff);                    // high byte leaves no lowercase set
        put_eol();
        put_byte(CHR_LPAREN);
        put_byte(CHR_RPAREN);
        put_eol();
        put_text("z");
        put_eol();
        put_text("INT.1234");               // heading at exactly the length cap
        put_eol();

        // Random screenplay blocks, mostly well formed
        total_items = script_items.size() + RANDOM_ITEMS;
        while (script_items.size() < total_items) begin
            case ($urandom_range(9))
                0, 1, 2: begin
                    if ($urandom_range(5) != 0) begin
                        put_eol();
                    end
                    put_caps_line(1, 12);
                    if ($urandom_range(2) == 0) begin
                        put_paren_line();
                    end
                    put_prose_line();
                    repeat ($urandom_range(0, 2)) begin
                        if ($urandom_range(2) == 0) begin
                            put_paren_line();
                        end
                        put_prose_line();
                    end
                end
                3, 4: begin
                    put_eol();
                    repeat ($urandom_range(1, 3)) begin
                        if ($urandom_range(4) == 0) begin
                            put_byte(CHR_BANG);
                        end
                        put_prose_line();
                    end
                end
                5: begin
                    put_eol();
                    put_heading_line();
                end
                6: begin
                    put_eol();
                    put_transition_line();
                end
                7: begin
                    repeat ($urandom_range(1, 3)) put_eol();
                end
                8: put_noise_line();
                default: put_broken_line();
            endcase
        end
        total_items = script_items.size();

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Drain: all items in, all classes back, then a short settle
        while (items_taken < total_items) @(posedge aclk);
        for (guard = 0; guard < 2000 && expected_classes.size() != 0; guard++) begin
            @(posedge aclk);
        end
        if (expected_classes.size() != 0) begin
            $display("%0t: %0d line classes never arrived", $time, expected_classes.size());
            mismatch_count++;
        end
        repeat (10) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("screenplay_line_classifier_unit_test: clean");
        end else begin
            $display("screenplay_line_classifier_unit_test: errors");
        end
        $finish;
    end

    // Stop a hung run
    initial begin
        #2_000_000;
        $display("screenplay_line_classifier_unit_test: errors");
        $finish;
    end

endmodule
